// File: hw/rtl/utcl_pkg.sv
// Shared types and constants for the UTC to local calendar converter.
// No dependencies; imported by utcl_civil and utc_to_local_calendar.
`default_nettype none

package utcl_pkg;

  // Day counts fit in 16 bits: 2^32 s / 86400 s is below 49711.
  localparam int DAYS_W        = 16;
  localparam int CIV_LAT       = 6;
  localparam int SECS_PER_DAY  = 86400;
  localparam int SECS_PER_HOUR = 3600;

  // Reset values of the configuration registers
  localparam logic [10:0] TZ_OFFSET_RESET  = 11'd60;
  localparam logic        DST_ENABLE_RESET = 1'b1;

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_TZ_OFFSET  = 1'b0,
    REG_DST_ENABLE = 1'b1
  } cfg_reg_t;

  // Civil date of one day count; spring marks March through December
  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [2:0]  week_day;
    logic [8:0]  doy;
    logic        spring;
  } civ_t;

endpackage

`default_nettype wire

// File: hw/rtl/utcl_civil.sv
// Six-stage pipeline from a day count since 1970-01-01 to a civil date.
// Also gives the March-based day of year and weekday. Depends on utcl_pkg.
`default_nettype none

module utcl_civil (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [utcl_pkg::DAYS_W-1:0] in_days,
  output logic                       out_valid,
  output utcl_pkg::civ_t             out_civ
);
  import utcl_pkg::*;

  localparam int EPOCH_SHIFT_DAYS = 719468;
  localparam int DAYS_PER_ERA     = 146097;
  localparam int DAYS_PER_CENT4   = 36524;

  // Reciprocals: m = ceil(2^(n+l)/d) gives an exact quotient for n-bit inputs
  localparam longint unsigned M7    = ((64'd1 << 20) + 64'd6) / 64'd7;
  localparam longint unsigned M1460 = ((64'd1 << 29) + 64'd1459) / 64'd1460;
  localparam longint unsigned M365  = ((64'd1 << 27) + 64'd364) / 64'd365;
  localparam longint unsigned M153  = ((64'd1 << 19) + 64'd152) / 64'd153;

  // Start of each March-based month within the year
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] ms;
    case (mp)
      4'd0:    ms = 9'd0;
      4'd1:    ms = 9'd31;
      4'd2:    ms = 9'd61;
      4'd3:    ms = 9'd92;
      4'd4:    ms = 9'd122;
      4'd5:    ms = 9'd153;
      4'd6:    ms = 9'd184;
      4'd7:    ms = 9'd214;
      4'd8:    ms = 9'd245;
      4'd9:    ms = 9'd275;
      4'd10:   ms = 9'd306;
      4'd11:   ms = 9'd337;
      default: ms = 9'd0;
    endcase
    return ms;
  endfunction

  logic [CIV_LAT-1:0] v_r;

  // Stage 1: era and day of era, weekday quotient
  logic [19:0] z;
  logic [2:0]  era_nxt;
  logic [17:0] doe_nxt;
  logic [16:0] x3_nxt;
  logic [34:0] wprod;
  logic [2:0]  era1_r;
  logic [17:0] doe1_r;
  logic [16:0] x3_1_r;
  logic [14:0] wq1_r;

  always_comb begin
    z = 20'(in_days) + 20'(EPOCH_SHIFT_DAYS);
    era_nxt = '0;
    for (int k = 1; k <= 5; k++) begin
      if (z >= 20'(k * DAYS_PER_ERA)) era_nxt = 3'(k);
    end
    doe_nxt = 18'(z - 20'(era_nxt) * 20'(DAYS_PER_ERA));
    x3_nxt  = 17'(in_days) + 17'd3;
    wprod   = 35'(x3_nxt) * 35'(M7);
  end

  always_ff @(posedge clk) begin
    era1_r <= era_nxt;
    doe1_r <= doe_nxt;
    x3_1_r <= x3_nxt;
    wq1_r  <= 15'(wprod >> 20);
  end

  // Stage 2: leap corrections of the day of era, weekday remainder
  logic [36:0] p1460;
  logic [6:0]  q1460;
  logic [2:0]  q36524;
  logic        q146096;
  logic [17:0] t_nxt;
  logic [2:0]  wd_nxt;
  logic [2:0]  era2_r;
  logic [17:0] doe2_r;
  logic [17:0] t2_r;
  logic [2:0]  wd2_r;

  always_comb begin
    p1460  = 37'(doe1_r) * 37'(M1460);
    q1460  = 7'(p1460 >> 29);
    q36524 = '0;
    for (int k = 1; k <= 4; k++) begin
      if (doe1_r >= 18'(k * DAYS_PER_CENT4)) q36524 = 3'(k);
    end
    q146096 = (doe1_r >= 18'(DAYS_PER_ERA - 1));
    t_nxt   = 18'(doe1_r - 18'(q1460) + 18'(q36524) - 18'(q146096));
    wd_nxt  = 3'(x3_1_r - 17'(wq1_r) * 17'd7);
  end

  always_ff @(posedge clk) begin
    era2_r <= era1_r;
    doe2_r <= doe1_r;
    t2_r   <= t_nxt;
    wd2_r  <= wd_nxt;
  end

  // Stage 3: year of era
  logic [36:0] p365;
  logic [2:0]  era3_r;
  logic [17:0] doe3_r;
  logic [8:0]  yoe3_r;
  logic [2:0]  wd3_r;

  assign p365 = 37'(t2_r) * 37'(M365);

  always_ff @(posedge clk) begin
    era3_r <= era2_r;
    doe3_r <= doe2_r;
    yoe3_r <= 9'(p365 >> 27);
    wd3_r  <= wd2_r;
  end

  // Stage 4: day of the March-based year
  logic [1:0]  c100;
  logic [8:0]  doy_nxt;
  logic [2:0]  era4_r;
  logic [8:0]  yoe4_r;
  logic [8:0]  doy4_r;
  logic [2:0]  wd4_r;

  always_comb begin
    c100 = '0;
    for (int k = 1; k <= 3; k++) begin
      if (yoe3_r >= 9'(k * 100)) c100 = 2'(k);
    end
    doy_nxt = 9'(doe3_r - (18'(yoe3_r) * 18'd365 + 18'(yoe3_r[8:2]) - 18'(c100)));
  end

  always_ff @(posedge clk) begin
    era4_r <= era3_r;
    yoe4_r <= yoe3_r;
    doy4_r <= doy_nxt;
    wd4_r  <= wd3_r;
  end

  // Stage 5: March-based month
  logic [10:0] x153;
  logic [22:0] p153;
  logic [2:0]  era5_r;
  logic [8:0]  yoe5_r;
  logic [8:0]  doy5_r;
  logic [2:0]  wd5_r;
  logic [3:0]  mp5_r;

  always_comb begin
    x153 = 11'(doy4_r) * 11'd5 + 11'd2;
    p153 = 23'(x153) * 23'(M153);
  end

  always_ff @(posedge clk) begin
    era5_r <= era4_r;
    yoe5_r <= yoe4_r;
    doy5_r <= doy4_r;
    wd5_r  <= wd4_r;
    mp5_r  <= 4'(p153 >> 19);
  end

  // Stage 6: calendar month, day and year
  civ_t civ_nxt;
  civ_t civ_r;

  always_comb begin
    civ_nxt.spring   = (mp5_r < 4'd10);
    civ_nxt.month    = civ_nxt.spring ? 4'(mp5_r + 4'd3) : 4'(mp5_r - 4'd9);
    civ_nxt.day      = 5'(doy5_r - month_start(mp5_r) + 9'd1);
    civ_nxt.year     = 12'(yoe5_r) + 12'(era5_r) * 12'd400 + 12'(!civ_nxt.spring);
    civ_nxt.week_day = wd5_r;
    civ_nxt.doy      = doy5_r;
  end

  always_ff @(posedge clk) begin
    civ_r <= civ_nxt;
  end

  // Valid bits travel with the stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[CIV_LAT-2:0], in_valid};
    end
  end

  assign out_valid = v_r[CIV_LAT-1];
  assign out_civ   = civ_r;

endmodule

`default_nettype wire

// File: hw/rtl/utc_to_local_calendar.sv
// Top level: Unix UTC seconds to local calendar with EU summer time.
// Depends on utcl_pkg and utcl_civil (two instances).
//
// Channel   Direction  Ports                                     Handshake
// input     in         start, busy, in_utc_seconds               start && !busy
// result    out        out_valid, out_year .. out_dst_active     one-cycle strobe
// config    in         cfg_we, cfg_index, cfg_wdata              cfg_we
//
// One timestamp per clock. Each timestamp passes through two six-stage
// calendar pipelines (UTC date for the summer time rule, then the local
// date) plus nine stages of day split, rule and offset.
// Reset is synchronous: it clears all valid bits and restores the registers.
// busy is always low and the receiver has no stall, so no beat is ever held.
`default_nettype none

module utc_to_local_calendar (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_utc_seconds,
  output logic        out_valid,
  output logic [11:0] out_year,
  output logic [3:0]  out_month,
  output logic [4:0]  out_day,
  output logic [2:0]  out_week_day,
  output logic [4:0]  out_hour,
  output logic [5:0]  out_minute,
  output logic [5:0]  out_second,
  output logic        out_dst_active,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [10:0] cfg_wdata
);
  import utcl_pkg::*;

  localparam int PIPE_LAT = 9 + 2 * CIV_LAT;

  // Reciprocals: m = ceil(2^(n+l)/d), exact for n-bit inputs
  localparam longint unsigned M675  = ((64'd1 << 35) + 64'd674) / 64'd675;
  localparam longint unsigned M7D   = ((64'd1 << 12) + 64'd6) / 64'd7;
  localparam longint unsigned M3600 = ((64'd1 << 29) + 64'd3599) / 64'd3600;
  localparam longint unsigned M60   = ((64'd1 << 23) + 64'd59) / 64'd60;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic       dst;
  } tod_t;

  // Configuration registers
  logic [10:0] tz_r;
  logic        dsten_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tz_r    <= TZ_OFFSET_RESET;
      dsten_r <= DST_ENABLE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_TZ_OFFSET:  tz_r    <= cfg_wdata;
        REG_DST_ENABLE: dsten_r <= cfg_wdata[0];
      endcase
    end
  end

  assign busy = 1'b0;

  // Valid bits of the stages owned here
  logic v0_r, v1_r, v2_r, v9_r, v10_r, v11_r, v12_r, v13_r, out_valid_r;
  logic va_civ, vb_civ;
  civ_t civa, civb;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r        <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v9_r        <= 1'b0;
      v10_r       <= 1'b0;
      v11_r       <= 1'b0;
      v12_r       <= 1'b0;
      v13_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v0_r        <= start && !busy;
      v1_r        <= v0_r;
      v2_r        <= v1_r;
      v9_r        <= va_civ;
      v10_r       <= v9_r;
      v11_r       <= v10_r;
      v12_r       <= v11_r;
      v13_r       <= v12_r;
      out_valid_r <= vb_civ;
    end
  end

  // Input beat capture
  logic [31:0] utc0_r;

  always_ff @(posedge clk) begin
    utc0_r <= in_utc_seconds;
  end

  // UTC day number: (s >> 7) / 675
  logic [50:0]       p1;
  logic [31:0]       utc1_r;
  logic [DAYS_W-1:0] days1_r;

  assign p1 = 51'(utc0_r[31:7]) * 51'(M675);

  always_ff @(posedge clk) begin
    utc1_r  <= utc0_r;
    days1_r <= DAYS_W'(p1 >> 35);
  end

  // UTC second of day
  logic [16:0]       sod2_nxt;
  logic [31:0]       utc2_r;
  logic [16:0]       sod2_r;
  logic [DAYS_W-1:0] days2_r;

  assign sod2_nxt = 17'(utc1_r - 32'(days1_r) * 32'(SECS_PER_DAY));

  always_ff @(posedge clk) begin
    utc2_r  <= utc1_r;
    sod2_r  <= sod2_nxt;
    days2_r <= days1_r;
  end

  // UTC calendar, with seconds delayed to match
  logic [31:0] utc_dl_r [CIV_LAT];
  logic [16:0] sod_dl_r [CIV_LAT];

  utcl_civil u_civ_utc (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v2_r),
    .in_days   (days2_r),
    .out_valid (va_civ),
    .out_civ   (civa)
  );

  always_ff @(posedge clk) begin
    utc_dl_r[0] <= utc2_r;
    sod_dl_r[0] <= sod2_r;
    for (int i = 1; i < CIV_LAT; i++) begin
      utc_dl_r[i] <= utc_dl_r[i-1];
      sod_dl_r[i] <= sod_dl_r[i-1];
    end
  end

  // Day of year modulo 7, quotient part
  logic [18:0] p7;
  logic [8:0]  doy9_r;
  logic [5:0]  q79_r;
  logic [2:0]  wd9_r;
  logic        spring9_r;
  logic [16:0] sod9_r;
  logic [31:0] utc9_r;

  assign p7 = 19'(civa.doy) * 19'(M7D);

  always_ff @(posedge clk) begin
    doy9_r    <= civa.doy;
    q79_r     <= 6'(p7 >> 12);
    wd9_r     <= civa.week_day;
    spring9_r <= civa.spring;
    sod9_r    <= sod_dl_r[CIV_LAT-1];
    utc9_r    <= utc_dl_r[CIV_LAT-1];
  end

  // Summer time window: last Sundays of March and October, 01:00 UTC.
  // Both are found from the weekday of today and the March-based day of year.
  logic [2:0]  r7;
  logic [2:0]  wk_a;
  logic [2:0]  wk_m;
  logic [8:0]  start_doy;
  logic [8:0]  end_doy;
  logic        after_start;
  logic        before_end;
  logic        on_nxt;
  logic        on10_r;
  logic [31:0] utc10_r;

  always_comb begin
    r7   = 3'(doy9_r - 9'(q79_r) * 9'd7);
    wk_a = (wd9_r >= r7) ? 3'(wd9_r - r7) : 3'(wd9_r + 3'd7 - r7);
    wk_m = (wk_a >= 3'd4) ? 3'(wk_a - 3'd4) : 3'(wk_a + 3'd3);
    start_doy   = 9'd30 - 9'(wk_m);
    end_doy     = 9'd244 - 9'(wk_a);
    after_start = (doy9_r > start_doy) ||
                  ((doy9_r == start_doy) && (sod9_r >= 17'(SECS_PER_HOUR)));
    before_end  = (doy9_r < end_doy) ||
                  ((doy9_r == end_doy) && (sod9_r < 17'(SECS_PER_HOUR)));
    on_nxt = dsten_r && spring9_r && after_start && before_end;
  end

  always_ff @(posedge clk) begin
    on10_r  <= on_nxt;
    utc10_r <= utc9_r;
  end

  // Local time: zone offset plus summer hour, wrapping at 32 bits
  logic signed [16:0] tz_ext;
  logic signed [16:0] tz_secs;
  logic [31:0]        shift;
  logic [31:0]        lt11_r;
  logic               on11_r;

  always_comb begin
    tz_ext  = {{6{tz_r[10]}}, tz_r};
    tz_secs = tz_ext * 17'sd60;
    shift   = {{15{tz_secs[16]}}, tz_secs} +
              (on10_r ? 32'(SECS_PER_HOUR) : 32'd0);
  end

  always_ff @(posedge clk) begin
    lt11_r <= utc10_r + shift;
    on11_r <= on10_r;
  end

  // Local day number
  logic [50:0]       p12;
  logic [31:0]       lt12_r;
  logic [DAYS_W-1:0] days12_r;
  logic              on12_r;

  assign p12 = 51'(lt11_r[31:7]) * 51'(M675);

  always_ff @(posedge clk) begin
    lt12_r   <= lt11_r;
    days12_r <= DAYS_W'(p12 >> 35);
    on12_r   <= on11_r;
  end

  // Local second of day
  logic [DAYS_W-1:0] days13_r;
  logic [16:0]       sod13_r;
  logic              on13_r;

  always_ff @(posedge clk) begin
    days13_r <= days12_r;
    sod13_r  <= 17'(lt12_r - 32'(days12_r) * 32'(SECS_PER_DAY));
    on13_r   <= on12_r;
  end

  // Local calendar
  utcl_civil u_civ_local (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v13_r),
    .in_days   (days13_r),
    .out_valid (vb_civ),
    .out_civ   (civb)
  );

  // Time of day beside the local calendar: quotients, then remainders
  logic [34:0] p_hr;
  logic [34:0] p_mt;
  logic [4:0]  hr_t1_r;
  logic [10:0] mtot_t1_r;
  logic [16:0] sod_t1_r;
  logic        on_t1_r;
  tod_t        tod_nxt;
  tod_t        tod2_r;
  tod_t        tod_dl_r [CIV_LAT-2];

  always_comb begin
    p_hr = 35'(sod13_r) * 35'(M3600);
    p_mt = 35'(sod13_r) * 35'(M60);
  end

  always_ff @(posedge clk) begin
    hr_t1_r   <= 5'(p_hr >> 29);
    mtot_t1_r <= 11'(p_mt >> 23);
    sod_t1_r  <= sod13_r;
    on_t1_r   <= on13_r;
  end

  always_comb begin
    tod_nxt.hour   = hr_t1_r;
    tod_nxt.minute = 6'(mtot_t1_r - 11'(hr_t1_r) * 11'd60);
    tod_nxt.second = 6'(sod_t1_r - 17'(mtot_t1_r) * 17'd60);
    tod_nxt.dst    = on_t1_r;
  end

  always_ff @(posedge clk) begin
    tod2_r      <= tod_nxt;
    tod_dl_r[0] <= tod2_r;
    for (int i = 1; i < CIV_LAT - 2; i++) begin
      tod_dl_r[i] <= tod_dl_r[i-1];
    end
  end

  // Result register
  civ_t civ_out_r;
  tod_t tod_out_r;

  always_ff @(posedge clk) begin
    civ_out_r <= civb;
    tod_out_r <= tod_dl_r[CIV_LAT-3];
  end

  assign out_valid      = out_valid_r;
  assign out_year       = civ_out_r.year;
  assign out_month      = civ_out_r.month;
  assign out_day        = civ_out_r.day;
  assign out_week_day   = civ_out_r.week_day;
  assign out_hour       = tod_out_r.hour;
  assign out_minute     = tod_out_r.minute;
  assign out_second     = tod_out_r.second;
  assign out_dst_active = tod_out_r.dst;

  // Every result beat comes from an input beat a fixed latency earlier
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, PIPE_LAT))
    else $error("result beat without matching input beat");

  // Summer hour only lands in local March through October
  a_dst_month: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_dst_active) |-> (out_month >= 4'd3 && out_month <= 4'd10))
    else $error("summer time outside March to October");

  // Calendar fields stay in range
  a_ranges: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hour < 5'd24 && out_minute < 6'd60 && out_second < 6'd60 &&
                   out_day != 5'd0 && out_week_day < 3'd7 &&
                   out_month != 4'd0 && out_month <= 4'd12))
    else $error("calendar field out of range");

endmodule

`default_nettype wire
